FILE: rtl/core/prq_pkg.sv
// Shared types, constants and slot arithmetic for the process run queue.
package prq_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = CNT_W + 1;

   localparam int OPCODE_W = 3;
   localparam int PID_W    = 32;
   localparam int STATE_W  = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int ENTRY_W  = PID_W + STATE_W;

   localparam logic [STATE_W-1:0] ROTATED_STATE = 8'h45;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ENQUEUE   = 3'd0,
      OP_PEEK_HEAD = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_POP_TAIL  = 3'd3,
      OP_LOOKUP    = 3'd4,
      OP_REMOVE    = 3'd5,
      OP_ROTATE    = 3'd6
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CLS_IMMEDIATE,
      CLS_SINGLE,
      CLS_WALK
   } op_class_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic single_fin;
      logic walk_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      op_class_type op_class;
      logic         walk_done;
   } stat_type;

   // Circular slot of the entry at a given offset from the head.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(offset);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

FILE: rtl/core/prq_ctrl.sv
// Sequencer for the process run queue: decode, read, walk and result transfer.
module prq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  prq_pkg::stat_type  stat,
   output prq_pkg::cmd_type   cmd
);
   import prq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_WALK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE:   cmd.load       = req_valid;
         S_DECODE: cmd.decide     = 1'b1;
         S_READ:   cmd.single_fin = 1'b1;
         S_WALK:   cmd.walk_step  = 1'b1;
         S_DONE:   cmd.out_load   = !rsp_valid_ff || !rsp_stall;
         default:  cmd = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (stat.op_class)
               CLS_SINGLE: state_in = S_READ;
               CLS_WALK:   state_in = S_WALK;
               default:    state_in = S_DONE;
            endcase
         end
         S_READ: state_in = S_DONE;
         S_WALK: begin
            if (stat.walk_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (cmd.out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/prq_datapath.sv
// Entry store, head and count registers, walk counters and result registers.
module prq_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  prq_pkg::cmd_type              cmd,
   output prq_pkg::stat_type             stat,
   input  logic [prq_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [prq_pkg::PID_W-1:0]     req_entry_pid,
   input  logic [prq_pkg::STATE_W-1:0]   req_entry_state,
   output logic [prq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [prq_pkg::PID_W-1:0]     rsp_out_pid,
   output logic [prq_pkg::STATE_W-1:0]   rsp_out_state,
   output logic [prq_pkg::COUNT_W-1:0]   rsp_out_count
);
   import prq_pkg::*;

   logic [OPCODE_W-1:0] op_ff;
   logic [PID_W-1:0]    pid_ff;
   logic [STATE_W-1:0]  st_ff;

   logic [IDX_W-1:0]    head_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    proc_idx_ff;
   logic [CNT_W-1:0]    kept_ff;
   logic                found_ff;
   logic [STATE_W-1:0]  first_state_ff;

   status_type          res_status_ff;
   logic [PID_W-1:0]    res_pid_ff;
   logic [STATE_W-1:0]  res_state_ff;

   logic [STATUS_W-1:0] rsp_status_ff;
   logic [PID_W-1:0]    rsp_pid_ff;
   logic [STATE_W-1:0]  rsp_state_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   logic [ENTRY_W-1:0]  entry_mem_ff [CAPACITY];
   logic [ENTRY_W-1:0]  rd_data_ff;

   logic [PID_W-1:0]    rd_pid;
   logic [STATE_W-1:0]  rd_state;
   logic [CNT_W-1:0]    count_dec;
   logic [CNT_W-1:0]    proc_inc;
   logic [CNT_W-1:0]    kept_inc;
   logic [IDX_W-1:0]    next_head;
   logic                full;
   logic                hit;
   logic                last;
   logic                any_found;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic                wr_en;

   assign rd_pid    = rd_data_ff[ENTRY_W-1:STATE_W];
   assign rd_state  = rd_data_ff[STATE_W-1:0];
   assign count_dec = count_ff - CNT_W'(1);
   assign proc_inc  = proc_idx_ff + CNT_W'(1);
   assign kept_inc  = kept_ff + CNT_W'(1);
   assign next_head = slot_of(head_ff, CNT_W'(1));
   assign full      = (count_ff >= CNT_W'(CAPACITY));
   assign hit       = (rd_pid == pid_ff);
   assign last      = (proc_idx_ff == count_dec);
   assign any_found = found_ff || hit;

   always_comb begin
      if (op_ff == OP_ENQUEUE || op_ff > OP_ROTATE || count_ff == '0) begin
         stat.op_class = CLS_IMMEDIATE;
      end else if (op_ff == OP_LOOKUP || op_ff == OP_REMOVE) begin
         stat.op_class = CLS_WALK;
      end else begin
         stat.op_class = CLS_SINGLE;
      end
      stat.walk_done = last || (op_ff == OP_LOOKUP && hit);
   end

   always_comb begin
      if (cmd.walk_step) begin
         rd_addr = slot_of(head_ff, proc_inc);
      end else if (op_ff == OP_POP_TAIL) begin
         rd_addr = slot_of(head_ff, count_dec);
      end else begin
         rd_addr = head_ff;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_of(head_ff, count_ff);
      wr_data = {pid_ff, st_ff};
      if (cmd.decide && op_ff == OP_ENQUEUE && !full) begin
         wr_en = 1'b1;
      end
      if (cmd.single_fin && op_ff == OP_ROTATE) begin
         wr_en   = 1'b1;
         wr_data = {rd_pid, ROTATED_STATE};
      end
      if (cmd.walk_step && op_ff == OP_REMOVE && !hit) begin
         wr_en   = 1'b1;
         wr_addr = slot_of(head_ff, kept_ff);
         wr_data = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         count_ff    <= '0;
         proc_idx_ff <= '0;
         kept_ff     <= '0;
         found_ff    <= 1'b0;
      end else begin
         if (cmd.decide) begin
            proc_idx_ff <= '0;
            kept_ff     <= '0;
            found_ff    <= 1'b0;
            if (op_ff == OP_ENQUEUE && !full) begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end
         if (cmd.single_fin) begin
            case (op_ff)
               OP_POP_HEAD: begin
                  head_ff  <= next_head;
                  count_ff <= count_dec;
               end
               OP_POP_TAIL: count_ff <= count_dec;
               OP_ROTATE:   head_ff  <= next_head;
               default: ;
            endcase
         end
         if (cmd.walk_step) begin
            proc_idx_ff <= proc_inc;
            if (op_ff == OP_REMOVE) begin
               if (!hit) kept_ff <= kept_inc;
               if (hit) found_ff <= 1'b1;
               if (last) count_ff <= hit ? kept_ff : kept_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         pid_ff <= req_entry_pid;
         st_ff  <= req_entry_state;
      end
      if (cmd.decide) begin
         if (op_ff == OP_ENQUEUE) begin
            res_status_ff <= full ? ST_FULL : ST_OK;
            res_pid_ff    <= pid_ff;
            res_state_ff  <= st_ff;
         end else begin
            res_status_ff <= (op_ff > OP_ROTATE) ? ST_OK : ST_EMPTY;
            res_pid_ff    <= '0;
            res_state_ff  <= '0;
         end
      end
      if (cmd.single_fin) begin
         res_status_ff <= ST_OK;
         res_pid_ff    <= rd_pid;
         res_state_ff  <= (op_ff == OP_ROTATE) ? ROTATED_STATE : rd_state;
      end
      if (cmd.walk_step) begin
         if (op_ff == OP_LOOKUP) begin
            if (hit) begin
               res_status_ff <= ST_OK;
               res_pid_ff    <= pid_ff;
               res_state_ff  <= rd_state;
            end else if (last) begin
               res_status_ff <= ST_NOTFOUND;
               res_pid_ff    <= '0;
               res_state_ff  <= '0;
            end
         end else begin
            if (hit && !found_ff) first_state_ff <= rd_state;
            if (last) begin
               res_status_ff <= any_found ? ST_OK : ST_NOTFOUND;
               res_pid_ff    <= any_found ? pid_ff : '0;
               if (found_ff) begin
                  res_state_ff <= first_state_ff;
               end else begin
                  res_state_ff <= hit ? rd_state : '0;
               end
            end
         end
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_pid_ff    <= res_pid_ff;
         rsp_state_ff  <= res_state_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_out_pid   = rsp_pid_ff;
   assign rsp_out_state = rsp_state_ff;
   assign rsp_out_count = COUNT_W'(rsp_count_ff);

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(head_ff) < SUM_W'(CAPACITY))
      else $error("head slot outside the store");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> proc_idx_ff < count_ff)
      else $error("walk visits an entry past the tail");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> kept_ff <= proc_idx_ff)
      else $error("compaction write ahead of the walk");
`endif

endmodule

FILE: rtl/core/process_run_queue.sv
// Process run queue top level: sequencer plus entry store datapath.
//
// Request channel (req_*): opcode, process id and state code. A transfer
// happens at a clock edge with req_valid high and req_stall low. The queue
// works on one request at a time; req_stall is high from the transfer until
// the result has been loaded into the output register.
// Result channel (rsp_*): status, entry id, state code and entry count after
// the operation, one result per request, held in an output register until
// taken. The next request is taken while that result still waits.
// Enqueue, unused opcodes and operations on an empty queue go from decode
// straight to the result; peek, pop and rotate first make one registered
// read of the entry store; lookup and remove walk the entries, one store
// read per cycle (up to all 64).
// A stalled result holds the block before its output register: finished work
// waits there and no new request is taken.
// Synchronous reset empties the queue (head and count cleared) and drops any
// pending result; the entry store itself is not cleared.
module process_run_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [prq_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [prq_pkg::PID_W-1:0]     req_entry_pid,
   input  logic [prq_pkg::STATE_W-1:0]   req_entry_state,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [prq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [prq_pkg::PID_W-1:0]     rsp_out_pid,
   output logic [prq_pkg::STATE_W-1:0]   rsp_out_state,
   output logic [prq_pkg::COUNT_W-1:0]   rsp_out_count
);
   import prq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   prq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   prq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_entry_pid   (req_entry_pid),
      .req_entry_state (req_entry_state),
      .rsp_status      (rsp_status),
      .rsp_out_pid     (rsp_out_pid),
      .rsp_out_state   (rsp_out_state),
      .rsp_out_count   (rsp_out_count)
   );

endmodule
